// ===== hdl/alpe_pkg.sv =====
package alpe_pkg;

    // Bus and pixel geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_CNT_W = $clog2(BITS_PER_PIXEL);

    // Register map: register index is taken from the word address.
    localparam logic REG_ONE_SYMBOL  = 1'b0;
    localparam logic REG_ZERO_SYMBOL = 1'b1;

    localparam logic [7:0] ONE_SYMBOL_RESET  = 8'd240;
    localparam logic [7:0] ZERO_SYMBOL_RESET = 8'd192;

    // Named colour codes; codes 8 to 15 are unknown.
    typedef enum logic [3:0] {
        COLOR_RED    = 4'd0,
        COLOR_GREEN  = 4'd1,
        COLOR_BLUE   = 4'd2,
        COLOR_WHITE  = 4'd3,
        COLOR_YELLOW = 4'd4,
        COLOR_VIOLET = 4'd5,
        COLOR_ORANGE = 4'd6,
        COLOR_BLACK  = 4'd7
    } color_code_t;

    localparam logic ACTION_NAMED = 1'b0;
    localparam logic ACTION_RAW   = 1'b1;

    // Input beat: one pixel.
    typedef struct packed {
        logic       action;
        logic [3:0] color_code;
        logic [7:0] brightness;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } pixel_in_t;

    // Output beat: one SPI symbol.
    typedef struct packed {
        logic [7:0] spi_symbol;
        logic       last_symbol;
    } symbol_out_t;

    // Colour map result: green, red, blue in sending order.
    typedef struct packed {
        logic                      known;
        logic [BITS_PER_PIXEL-1:0] grb;
    } pixel_map_t;

endpackage

// ===== hdl/alpe_color_map.sv =====
module alpe_color_map (
    input  alpe_pkg::pixel_in_t  pixel,
    output alpe_pkg::pixel_map_t map
);
    import alpe_pkg::*;

    logic [7:0] bri;

    assign bri = pixel.brightness;

    // Turn a named colour or a raw pixel into the green, red, blue word.
    always_comb
    begin
        map.known = 1'b1;
        map.grb   = '0;
        if (pixel.action == ACTION_RAW)
        begin
            map.grb = {pixel.green_level, pixel.red_level, pixel.blue_level};
        end
        else
        begin
            case (color_code_t'(pixel.color_code))
                COLOR_RED:    map.grb = {8'd0, bri, 8'd0};
                COLOR_GREEN:  map.grb = {bri, 8'd0, 8'd0};
                COLOR_BLUE:   map.grb = {8'd0, 8'd0, bri};
                COLOR_WHITE:  map.grb = {bri, bri, bri};
                COLOR_YELLOW: map.grb = {bri, bri, 8'd0};
                COLOR_VIOLET: map.grb = {8'd0, bri, bri};
                COLOR_ORANGE: map.grb = {{1'b0, bri[7:1]}, bri, 8'd0};
                COLOR_BLACK:  map.grb = '0;
                default:      map.known = 1'b0;
            endcase
        end
    end

endmodule

// ===== hdl/addressable_led_pixel_encoder_top.sv =====
// Addressable LED pixel encoder.
//
// Pixel channel (pixel_valid / pixel_ready / pixel): each beat is one pixel,
// either a named colour with a brightness or raw red, green and blue levels.
// Symbol channel (symbol_valid / symbol_ready / symbol): each beat is one SPI
// byte standing for one LED data bit, green then red then blue, most
// significant bit first. The 24th symbol of a pixel has last_symbol set.
// A pixel with an unknown colour code is taken and produces nothing.
//
// The pixel beat loads the shift register, and the first symbol is then
// registered in the symbol register, from which it is offered.
// Throughput: one symbol per cycle while the receiver takes them; the pixel
// shift register is the limit, and it takes the next pixel in the same cycle
// as it hands over its last bit, so pixels stream without gaps.
// A stalled receiver holds the symbol register and the shift register; the
// pixel channel then stalls once the shift register is busy.
// Reset empties both registers and loads the symbol bytes 240 and 192; the
// APB registers may be rewritten while the block is idle.
module addressable_led_pixel_encoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  alpe_pkg::pixel_in_t                 pixel,
    output logic                                symbol_valid,
    input  logic                                symbol_ready,
    output alpe_pkg::symbol_out_t               symbol,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [alpe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [alpe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [alpe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import alpe_pkg::*;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_PIXEL - 1);

    logic [7:0]                one_symbol_reg;
    logic [7:0]                zero_symbol_reg;
    logic                      reg_sel;
    logic                      cfg_write;

    pixel_map_t                map;
    logic                      pix_valid_reg;
    logic                      pix_valid_next;
    logic [BITS_PER_PIXEL-1:0] grb_reg;
    logic [BITS_PER_PIXEL-1:0] grb_next;
    logic [BIT_CNT_W-1:0]      cnt_reg;
    logic [BIT_CNT_W-1:0]      cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    symbol_out_t               out_reg;
    symbol_out_t               out_next;

    logic                      accept;
    logic                      advance;
    logic                      last_bit;

    // Configuration registers over APB.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_symbol_reg  <= ONE_SYMBOL_RESET;
            zero_symbol_reg <= ZERO_SYMBOL_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_ONE_SYMBOL)
            begin
                one_symbol_reg <= pwdata[7:0];
            end
            else
            begin
                zero_symbol_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ONE_SYMBOL:  prdata = {(APB_DATA_W - 8)'(0), one_symbol_reg};
            REG_ZERO_SYMBOL: prdata = {(APB_DATA_W - 8)'(0), zero_symbol_reg};
            default:         prdata = '0;
        endcase
    end

    // Colour mapping ahead of the shift register.
    alpe_color_map u_map (
        .pixel (pixel),
        .map   (map)
    );

    // Handshake: shift one bit out whenever the symbol register can take it.
    assign last_bit     = (cnt_reg == LAST_BIT);
    assign advance      = pix_valid_reg && (!out_valid_reg || symbol_ready);
    assign pixel_ready  = !pix_valid_reg || (advance && last_bit);
    assign accept       = pixel_valid && pixel_ready;
    assign symbol_valid = out_valid_reg;
    assign symbol       = out_reg;

    // Next state of the shift register and the symbol register.
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        grb_next       = grb_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next       = 1'b1;
            out_next.spi_symbol  = grb_reg[BITS_PER_PIXEL-1] ? one_symbol_reg
                                                             : zero_symbol_reg;
            out_next.last_symbol = last_bit;
            grb_next             = {grb_reg[BITS_PER_PIXEL-2:0], 1'b0};
            cnt_next             = cnt_reg + 1'b1;
            if (last_bit)
            begin
                pix_valid_next = 1'b0;
            end
        end
        else if (symbol_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            pix_valid_next = map.known;
            grb_next       = map.grb;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grb_reg <= grb_next;
        out_reg <= out_next;
    end

endmodule

// ===== hdl/alpe_checker.sv =====
module alpe_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_ready,
    input alpe_pkg::pixel_in_t   pixel,
    input logic                  symbol_valid,
    input logic                  symbol_ready,
    input alpe_pkg::symbol_out_t symbol
);
    import alpe_pkg::*;

    // A stalled symbol beat stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_ready |=> symbol_valid && $stable(symbol))
        else $error("symbol beat changed while stalled");

    // A pixel with a known colour occupies the encoder in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && (pixel.action || !pixel.color_code[3])
        |=> !pixel_ready)
        else $error("encoder free straight after a known pixel");

    // While the encoder is busy a symbol is on offer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |=> symbol_valid)
        else $error("busy encoder offers no symbol");

endmodule

bind addressable_led_pixel_encoder_top alpe_checker u_alpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol)
);
